>>> hdl/ladder_key_and_power_press_scanner_unit_macros.svh
// Assertion macros shared by the scanner RTL.
// Each macro checks one property on the rising clock edge and stays quiet
// while the synchronous active-low reset is asserted.
`ifndef LADDER_KEY_AND_POWER_PRESS_SCANNER_UNIT_MACROS_SVH
`define LADDER_KEY_AND_POWER_PRESS_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication
`define LKP_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define LKP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lkp_pkg.sv
package lkp_pkg;

    // Widths of the ladder path and the tick limits
    localparam int ADC_BITS       = 10;
    localparam int TICK_BITS      = 8;
    localparam int KEY_BITS       = 10;
    localparam int GPIO_BITS      = 6;
    localparam int NUM_LEVELS     = 5;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = ADC_BITS;
    localparam int INJECT_BITS    = 2;

    // Number of scans replaced by ENTER after a short press
    localparam logic [INJECT_BITS-1:0] ENTER_INJECT_SCANS = 2'd2;

    // Key code bit positions
    localparam logic [KEY_BITS-1:0] KEY_UP       = 10'h001;
    localparam logic [KEY_BITS-1:0] KEY_DOWN     = 10'h002;
    localparam logic [KEY_BITS-1:0] KEY_MENU     = 10'h004;
    localparam logic [KEY_BITS-1:0] KEY_CUSTOM1  = 10'h008;
    localparam logic [KEY_BITS-1:0] KEY_SHUTTER2 = 10'h010;
    localparam logic [KEY_BITS-1:0] KEY_LEFT     = 10'h020;
    localparam logic [KEY_BITS-1:0] KEY_SHUTTER1 = 10'h040;
    localparam logic [KEY_BITS-1:0] KEY_ZOOMIN   = 10'h080;
    localparam logic [KEY_BITS-1:0] KEY_ZOOMOUT  = 10'h100;
    localparam logic [KEY_BITS-1:0] KEY_ENTER    = 10'h200;

    typedef logic [NUM_LEVELS-1:0][KEY_BITS-1:0] level_key_tab_t;
    typedef logic [GPIO_BITS-1:0][KEY_BITS-1:0]  button_line_tab_t;

    // Key reported by each ladder level, level 4 first and level 0 last
    localparam level_key_tab_t LEVEL_KEY = '{KEY_CUSTOM1, KEY_DOWN, KEY_MENU,
                                             KEY_SHUTTER2, KEY_UP};

    // Key reported by each GPIO bit, bit 5 first and bit 0 last
    localparam button_line_tab_t BUTTON_LINE_KEY = '{KEY_ENTER, KEY_ZOOMOUT, KEY_ZOOMIN,
                                                     KEY_SHUTTER2, KEY_SHUTTER1, KEY_LEFT};

    // Register reset values
    localparam logic [ADC_BITS-1:0]  HALF_WIDTH_RST = 10'd20;
    localparam logic [ADC_BITS-1:0]  LEVEL0_RST     = 10'd0;
    localparam logic [ADC_BITS-1:0]  LEVEL1_RST     = 10'd91;
    localparam logic [ADC_BITS-1:0]  LEVEL2_RST     = 10'd177;
    localparam logic [ADC_BITS-1:0]  LEVEL3_RST     = 10'd253;
    localparam logic [ADC_BITS-1:0]  LEVEL4_RST     = 10'd340;
    localparam logic [TICK_BITS-1:0] LONG_RST       = 8'd20;
    localparam logic [TICK_BITS-1:0] SHORT_RST      = 8'd16;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_HALF_WIDTH = 3'd0,
        CFG_LEVEL0     = 3'd1,
        CFG_LEVEL1     = 3'd2,
        CFG_LEVEL2     = 3'd3,
        CFG_LEVEL3     = 3'd4,
        CFG_LEVEL4     = 3'd5,
        CFG_LONG_TICKS = 3'd6,
        CFG_SHORT_TICKS = 3'd7
    } cfg_index_t;

    // Poll kinds
    typedef enum logic {
        FUNC_KEY_SCAN   = 1'b0,
        FUNC_POWER_POLL = 1'b1
    } func_t;

    typedef logic [NUM_LEVELS-1:0][ADC_BITS-1:0] level_centres_t;

    typedef struct packed {
        logic                 func;
        logic [ADC_BITS-1:0]  adc_sample;
        logic [GPIO_BITS-1:0] gpio_keys;
        logic                 power_pressed;
    } lkp_in_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key_code;
        logic                power_off;
    } lkp_out_t;

endpackage

>>> hdl/lkp_ladder_match.sv
module lkp_ladder_match
    import lkp_pkg::*;
(
    input  logic [ADC_BITS-1:0] sample,
    input  logic [ADC_BITS-1:0] half_width,
    input  level_centres_t      centres,
    output logic [KEY_BITS-1:0] ladder_key
);

    logic [NUM_LEVELS-1:0] hit;

    // Compare the sample against every window in parallel
    always_comb begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (sample >= centres[i]) begin
                hit[i] = (sample - centres[i]) <= half_width;
            end else begin
                hit[i] = (centres[i] - sample) <= half_width;
            end
        end
    end

    // Pick the lowest-numbered matching level
    always_comb begin
        ladder_key = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                ladder_key = LEVEL_KEY[i];
            end
        end
    end

endmodule

>>> hdl/ladder_key_and_power_press_scanner_unit.sv
// Channel  Ports                      Payload    Direction
// -------  -------------------------  ---------  ---------
// poll     s_valid s_ready s_data     lkp_in_t   in
// result   m_valid m_ready m_data     lkp_out_t  out
// config   cfg_wr_en cfg_index cfg_wdata  -      in
//
// One result per poll: an accepted poll waits in the input register and moves
// into the result register when the output is free, which raises m_valid.
// A new poll can be accepted every cycle while s_ready is high; s_ready drops
// only when the input and result registers are both full and m_ready is low.
// Shared press state updates as a poll moves into the result register.
// Synchronous active-low reset restores the register defaults and press state.
module ladder_key_and_power_press_scanner_unit
    import lkp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  lkp_in_t                   s_data,

    output logic                      m_valid,
    input  logic                      m_ready,
    output lkp_out_t                  m_data
);

    // Configuration registers
    logic [ADC_BITS-1:0]  half_width_reg;
    level_centres_t       centres_reg;
    logic [TICK_BITS-1:0] long_ticks_reg;
    logic [TICK_BITS-1:0] short_ticks_reg;

    // Press state
    logic [TICK_BITS-1:0]   held_count_reg, held_count_next;
    logic                   since_reset_hold_reg, since_reset_hold_next;
    logic                   short_press_event_reg, short_press_event_next;
    logic [INJECT_BITS-1:0] enter_inject_count_reg, enter_inject_count_next;

    // Pipeline registers
    logic     in_valid_reg, in_valid_next;
    lkp_in_t  in_item_reg;
    logic     m_valid_reg, m_valid_next;
    lkp_out_t out_item_reg, out_item_next;

    logic                   out_free;
    logic                   advance;
    logic                   s_take;
    logic [KEY_BITS-1:0]    ladder_key;
    logic [KEY_BITS-1:0]    gpio_code;
    logic [INJECT_BITS-1:0] inject_inc;
    logic [TICK_BITS-1:0]   held_inc;

    // Handshake
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_take   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_item_reg;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg  <= HALF_WIDTH_RST;
            centres_reg[0]  <= LEVEL0_RST;
            centres_reg[1]  <= LEVEL1_RST;
            centres_reg[2]  <= LEVEL2_RST;
            centres_reg[3]  <= LEVEL3_RST;
            centres_reg[4]  <= LEVEL4_RST;
            long_ticks_reg  <= LONG_RST;
            short_ticks_reg <= SHORT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_HALF_WIDTH:  half_width_reg  <= cfg_wdata;
                CFG_LEVEL0:      centres_reg[0]  <= cfg_wdata;
                CFG_LEVEL1:      centres_reg[1]  <= cfg_wdata;
                CFG_LEVEL2:      centres_reg[2]  <= cfg_wdata;
                CFG_LEVEL3:      centres_reg[3]  <= cfg_wdata;
                CFG_LEVEL4:      centres_reg[4]  <= cfg_wdata;
                CFG_LONG_TICKS:  long_ticks_reg  <= cfg_wdata[TICK_BITS-1:0];
                CFG_SHORT_TICKS: short_ticks_reg <= cfg_wdata[TICK_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Ladder window match
    lkp_ladder_match u_ladder (
        .sample     (in_item_reg.adc_sample),
        .half_width (half_width_reg),
        .centres    (centres_reg),
        .ladder_key (ladder_key)
    );

    // Map the GPIO keys onto key code bits
    always_comb begin
        gpio_code = '0;
        for (int i = 0; i < GPIO_BITS; i++) begin
            if (in_item_reg.gpio_keys[i]) begin
                gpio_code = gpio_code | BUTTON_LINE_KEY[i];
            end
        end
    end

    assign inject_inc = enter_inject_count_reg + 1'b1;
    assign held_inc   = (held_count_reg == '1) ? held_count_reg : held_count_reg + 1'b1;

    // Evaluate the held poll against the press state
    always_comb begin
        held_count_next         = held_count_reg;
        since_reset_hold_next   = since_reset_hold_reg;
        short_press_event_next  = short_press_event_reg;
        enter_inject_count_next = enter_inject_count_reg;
        out_item_next           = '0;

        if (in_item_reg.func == FUNC_KEY_SCAN) begin
            out_item_next.key_code = ladder_key | gpio_code;
            // Replace the code with ENTER for ENTER_INJECT_SCANS scans after a short press
            if (short_press_event_reg) begin
                if (inject_inc > ENTER_INJECT_SCANS) begin
                    enter_inject_count_next = '0;
                    short_press_event_next  = 1'b0;
                end else begin
                    enter_inject_count_next = inject_inc;
                    out_item_next.key_code  = KEY_ENTER;
                end
            end
        end else begin
            if (in_item_reg.power_pressed) begin
                // Count the hold unless it started before reset ended
                if (!since_reset_hold_reg) begin
                    held_count_next         = held_inc;
                    out_item_next.power_off = held_inc > long_ticks_reg;
                end
            end else begin
                since_reset_hold_next = 1'b0;
                if (held_count_reg != '0 && held_count_reg < short_ticks_reg) begin
                    short_press_event_next = 1'b1;
                end
                held_count_next = '0;
            end
        end
    end

    // Advance the valid flags
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Hold control and press state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg           <= 1'b0;
            m_valid_reg            <= 1'b0;
            held_count_reg         <= '0;
            since_reset_hold_reg   <= 1'b1;
            short_press_event_reg  <= 1'b0;
            enter_inject_count_reg <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (advance) begin
                held_count_reg         <= held_count_next;
                since_reset_hold_reg   <= since_reset_hold_next;
                short_press_event_reg  <= short_press_event_next;
                enter_inject_count_reg <= enter_inject_count_next;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg <= out_item_next;
        end
    end

`include "ladder_key_and_power_press_scanner_unit_macros.svh"

    `LKP_ASSERT_SAME(a_inject_needs_event, aclk, aresetn,
        enter_inject_count_reg != '0, short_press_event_reg,
        "ENTER injection count without pending event")
    `LKP_ASSERT_SAME(a_inject_bounded, aclk, aresetn,
        1'b1, enter_inject_count_reg <= ENTER_INJECT_SCANS,
        "ENTER injection count past limit")
    `LKP_ASSERT_SAME(a_reset_hold_no_count, aclk, aresetn,
        since_reset_hold_reg, held_count_reg == '0,
        "held count moved during hold since reset")
    `LKP_ASSERT_SAME(a_power_off_no_key, aclk, aresetn,
        m_valid_reg && out_item_reg.power_off, out_item_reg.key_code == '0,
        "power-off result carries a key code")
    `LKP_ASSERT_NEXT(a_result_follows, aclk, aresetn,
        advance, m_valid_reg,
        "advanced poll produced no result")

endmodule
